/* rtl/cmmt_pkg.sv */
// ----------------------------------------------------------------------------
// Cell min/max/mean tracker package
// Shared widths, metric codes and the sequencer state type.
// ----------------------------------------------------------------------------
package cmmt_pkg;

    // Number of tracked metrics and the width of a metric index.
    localparam int NUM_METRICS = 4;
    localparam int METRIC_W    = 2;

    // Fixed field widths of the stream payloads.
    localparam int TAG_W   = 6;
    localparam int POS_W   = 9;
    localparam int CELL_W  = 10;
    localparam int FIELD_W = 16;

    // Packed stream widths; the data widths are padded to whole bytes.
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    typedef logic [METRIC_W-1:0] metric_t;

    // Metric codes.
    localparam metric_t METRIC_VOLTAGE     = 2'd0;
    localparam metric_t METRIC_TEMPERATURE = 2'd1;
    localparam metric_t METRIC_CHARGE      = 2'd2;
    localparam metric_t METRIC_HEALTH      = 2'd3;
    localparam metric_t METRIC_LAST        = METRIC_HEALTH;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUTPUT
    } state_t;

endpackage

/* rtl/cell_min_max_mean_tracker_unit.sv */
// ----------------------------------------------------------------------------
// Cell min/max/mean tracker
// Per-cluster running extremes and averages of battery cell readings.
// ----------------------------------------------------------------------------
// Each accepted cell request is latched; a single compare-and-accumulate unit
// then steps through voltage, temperature, charge state and health state. A
// request with tlast set produces four results, one per metric; each result
// waits for the shared bit-serial divider and then holds until it is taken.
// The input side is not ready while any of this is in progress. After the
// fourth result all statistics are cleared for the next cluster.
// ----------------------------------------------------------------------------
module cell_min_max_mean_tracker_unit #(
    parameter int MAX_CELLS   = 512,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Cell readings.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0: cluster_number, cell_position, cell_voltage,
    // cell_temperature, cell_charge_state, cell_health_state, zero pad.
    input  logic [cmmt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,     // final_cell
    // Per-metric results.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0: cluster_tag, max_value, max_cell, min_value, min_cell,
    // mean_value, zero pad.
    output logic [cmmt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [cmmt_pkg::M_TUSER_W-1:0] m_tuser,     // metric
    output logic                           m_tlast      // last_metric
);
    import cmmt_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam logic [CNT_W-1:0]       CNT_LIMIT   = CNT_W'(MAX_CELLS);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONES = '1;

    // Sequencer.
    state_t  state_reg, state_next;
    metric_t metric_reg, metric_next;

    // Latched request.
    logic [TAG_W-1:0]       tag_reg;
    logic [CELL_W-1:0]      cell_no_reg;
    logic                   final_reg;
    logic                   take_reg;
    logic [SAMPLE_BITS-1:0] sample_reg [NUM_METRICS];

    // Running statistics.
    logic [SAMPLE_BITS-1:0] max_reg      [NUM_METRICS];
    logic [CELL_W-1:0]      max_cell_reg [NUM_METRICS];
    logic [SAMPLE_BITS-1:0] min_reg      [NUM_METRICS];
    logic [CELL_W-1:0]      min_cell_reg [NUM_METRICS];
    logic [SUM_W-1:0]       sum_reg      [NUM_METRICS];
    logic [CNT_W-1:0]       count_reg;

    // Output holding registers.
    logic [SAMPLE_BITS-1:0] out_max_reg;
    logic [CELL_W-1:0]      out_max_cell_reg;
    logic [SAMPLE_BITS-1:0] out_min_reg;
    logic [CELL_W-1:0]      out_min_cell_reg;
    logic [SAMPLE_BITS-1:0] out_mean_reg;

    logic                   s_accept;
    logic                   accum_en;
    logic                   clear_stats;
    logic                   load_out;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quotient;

    logic [SAMPLE_BITS-1:0] cur_sample;
    logic                   upd_max;
    logic                   upd_min;
    logic [SUM_W-1:0]       sum_add;

    assign s_accept = s_tvalid && s_tready;

    // Capture the request; readings keep their low SAMPLE_BITS bits.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tag_reg       <= s_tdata[5:0];
            cell_no_reg   <= {1'b0, s_tdata[14:6]} + 1'b1;
            final_reg     <= s_tlast;
            take_reg      <= (count_reg < CNT_LIMIT);
            sample_reg[0] <= s_tdata[15 +: SAMPLE_BITS];
            sample_reg[1] <= s_tdata[31 +: SAMPLE_BITS];
            sample_reg[2] <= s_tdata[47 +: SAMPLE_BITS];
            sample_reg[3] <= s_tdata[63 +: SAMPLE_BITS];
        end
    end

    // Shared compare-and-accumulate unit, working on one metric per cycle.
    always_comb begin
        cur_sample = sample_reg[metric_reg];
        upd_max    = (cur_sample > max_reg[metric_reg]);
        upd_min    = (cur_sample < min_reg[metric_reg]);
        sum_add    = sum_reg[metric_reg] + SUM_W'(cur_sample);
    end

    assign accum_en = (state_reg == ST_ACCUM) && take_reg;

    // Statistics registers: updated during accumulation, cleared after a run.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_stats) begin
            for (int m = 0; m < NUM_METRICS; m++) begin
                max_reg[m]      <= '0;
                max_cell_reg[m] <= '0;
                min_reg[m]      <= SAMPLE_ONES;
                min_cell_reg[m] <= '0;
                sum_reg[m]      <= '0;
            end
            count_reg <= '0;
        end else begin
            if (s_accept && (count_reg < CNT_LIMIT)) begin
                count_reg <= count_reg + 1'b1;
            end
            if (accum_en) begin
                if (upd_max) begin
                    max_reg[metric_reg]      <= cur_sample;
                    max_cell_reg[metric_reg] <= cell_no_reg;
                end
                if (upd_min) begin
                    min_reg[metric_reg]      <= cur_sample;
                    min_cell_reg[metric_reg] <= cell_no_reg;
                end
                sum_reg[metric_reg] <= sum_add;
            end
        end
    end

    // Shared divider for the per-metric averages.
    cmmt_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg[metric_reg]),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Load the result for the current metric once its average is ready.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_max_reg      <= max_reg[metric_reg];
            out_max_cell_reg <= max_cell_reg[metric_reg];
            out_min_reg      <= min_reg[metric_reg];
            out_min_cell_reg <= min_cell_reg[metric_reg];
            out_mean_reg     <= div_quotient[SAMPLE_BITS-1:0];
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            metric_reg <= METRIC_VOLTAGE;
        end else begin
            state_reg  <= state_next;
            metric_reg <= metric_next;
        end
    end

    // Next state and control outputs.
    always_comb begin
        state_next  = state_reg;
        metric_next = metric_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        clear_stats = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next  = ST_ACCUM;
                    metric_next = METRIC_VOLTAGE;
                end
            end
            ST_ACCUM: begin
                if (metric_reg == METRIC_LAST) begin
                    metric_next = METRIC_VOLTAGE;
                    state_next  = final_reg ? ST_DIV_START : ST_IDLE;
                end else begin
                    metric_next = metric_reg + 1'b1;
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    load_out   = 1'b1;
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (metric_reg == METRIC_LAST) begin
                        clear_stats = 1'b1;
                        metric_next = METRIC_VOLTAGE;
                        state_next  = ST_IDLE;
                    end else begin
                        metric_next = metric_reg + 1'b1;
                        state_next  = ST_DIV_START;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result packing.
    assign m_tdata = {6'b0,
                      FIELD_W'(out_mean_reg),
                      out_min_cell_reg,
                      FIELD_W'(out_min_reg),
                      out_max_cell_reg,
                      FIELD_W'(out_max_reg),
                      tag_reg};
    assign m_tuser = metric_reg;
    assign m_tlast = (metric_reg == METRIC_LAST);

endmodule

/* rtl/cmmt_div.sv */
// ----------------------------------------------------------------------------
// Cell min/max/mean tracker divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmmt_div #(
    parameter int DIVIDEND_W = 25,
    parameter int DIVISOR_W  = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One trial subtraction: bring down the next dividend bit.
    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = (trial >= {1'b0, divisor_reg});
    end

    // Control: step counter, busy flag and a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/cmmt_checker.sv */
// ----------------------------------------------------------------------------
// Cell min/max/mean tracker checker
// Port-level properties of the tracker, attached by a bind statement.
// ----------------------------------------------------------------------------
module cmmt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cmmt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [cmmt_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import cmmt_pkg::*;

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The block never takes a request while a result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // The run marker sits on the health metric only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == METRIC_LAST)))
        else $error("last_metric does not match the metric code");

    // A run continues after a non-final result and ends after the final one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("input ready in the middle of a result run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("input not ready after the last result");

endmodule

bind cell_min_max_mean_tracker_unit cmmt_checker u_cmmt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* test/cell_stats_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cell statistics checker
// Watches both stream channels of the min/max/mean tracker. Every accepted
// cell request is folded into a private copy of the per-metric statistics.
// A final cell queues the four metric reports that the block must send.
// Every accepted result is compared field by field with the oldest queued
// report.
// ----------------------------------------------------------------------------
module cell_stats_checker #(
    parameter int MAX_CELLS = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [cmmt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [cmmt_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [cmmt_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             results_pending
);
    import cmmt_pkg::*;

    localparam int SUM_W     = 25;

    // Bit offsets of the input request fields.
    localparam int S_TAG_LO  = 0;
    localparam int S_POS_LO  = S_TAG_LO + TAG_W;
    localparam int S_READ_LO = S_POS_LO + POS_W;

    // Bit offsets of the result fields.
    localparam int M_TAG_LO      = 0;
    localparam int M_MAX_LO      = M_TAG_LO + TAG_W;
    localparam int M_MAX_CELL_LO = M_MAX_LO + FIELD_W;
    localparam int M_MIN_LO      = M_MAX_CELL_LO + CELL_W;
    localparam int M_MIN_CELL_LO = M_MIN_LO + FIELD_W;
    localparam int M_MEAN_LO     = M_MIN_CELL_LO + CELL_W;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        metric_t            metric;
        logic [FIELD_W-1:0] max_value;
        logic [CELL_W-1:0]  max_cell;
        logic [FIELD_W-1:0] min_value;
        logic [CELL_W-1:0]  min_cell;
        logic [FIELD_W-1:0] mean_value;
        logic               last_metric;
    } metric_report_t;

    // Running statistics of the cluster being collected.
    logic [FIELD_W-1:0] peak_value  [NUM_METRICS];
    logic [CELL_W-1:0]  peak_cell   [NUM_METRICS];
    logic [FIELD_W-1:0] floor_value [NUM_METRICS];
    logic [CELL_W-1:0]  floor_cell  [NUM_METRICS];
    logic [SUM_W-1:0]   reading_sum [NUM_METRICS];
    logic [CELL_W-1:0]  cells_counted;

    metric_report_t     expected_reports [$];
    metric_report_t     got_report;
    metric_report_t     want_report;
    metric_report_t     new_report;
    logic [FIELD_W-1:0] reading [NUM_METRICS];
    logic [CELL_W-1:0]  cell_number;
    logic [SUM_W-1:0]   quotient;

    // Prints one line for each mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("cluster %0d metric %0d %s: got %0h, expected %0h",
                                      want_report.tag, want_report.metric, name, got, want));
    endtask

    task automatic clear_stats();
        for (int m = 0; m < NUM_METRICS; m++) begin
            peak_value[m]  = '0;
            peak_cell[m]   = '0;
            floor_value[m] = '1;
            floor_cell[m]  = '0;
            reading_sum[m] = '0;
        end
        cells_counted = '0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_stats();
            expected_reports.delete();
        end else begin
            // Check a result taken by the receiver against the oldest report.
            if (m_tvalid && m_tready) begin
                got_report.tag         = m_tdata[M_TAG_LO +: TAG_W];
                got_report.metric      = metric_t'(m_tuser);
                got_report.max_value   = m_tdata[M_MAX_LO +: FIELD_W];
                got_report.max_cell    = m_tdata[M_MAX_CELL_LO +: CELL_W];
                got_report.min_value   = m_tdata[M_MIN_LO +: FIELD_W];
                got_report.min_cell    = m_tdata[M_MIN_CELL_LO +: CELL_W];
                got_report.mean_value  = m_tdata[M_MEAN_LO +: FIELD_W];
                got_report.last_metric = m_tlast;
                if (expected_reports.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, cluster %0d metric %0d",
                                              got_report.tag, got_report.metric));
                end else begin
                    want_report = expected_reports.pop_front();
                    check_field("cluster_tag", got_report.tag, want_report.tag);
                    check_field("metric", got_report.metric, want_report.metric);
                    check_field("max_value", got_report.max_value, want_report.max_value);
                    check_field("max_cell", got_report.max_cell, want_report.max_cell);
                    check_field("min_value", got_report.min_value, want_report.min_value);
                    check_field("min_cell", got_report.min_cell, want_report.min_cell);
                    check_field("mean_value", got_report.mean_value,
                                want_report.mean_value);
                    check_field("last_metric", got_report.last_metric,
                                want_report.last_metric);
                end
            end

            // Fold an accepted cell into the statistics.
            if (s_tvalid && s_tready) begin
                cell_number = {1'b0, s_tdata[S_POS_LO +: POS_W]} + 1'b1;
                for (int m = 0; m < NUM_METRICS; m++)
                    reading[m] = s_tdata[S_READ_LO + m*FIELD_W +: FIELD_W];

                // Cells past the capacity of a cluster are left out entirely.
                if (cells_counted < MAX_CELLS) begin
                    for (int m = 0; m < NUM_METRICS; m++) begin
                        // Strict compares: the first cell reaching an extreme keeps it.
                        if (reading[m] > peak_value[m]) begin
                            peak_value[m] = reading[m];
                            peak_cell[m]  = cell_number;
                        end
                        if (reading[m] < floor_value[m]) begin
                            floor_value[m] = reading[m];
                            floor_cell[m]  = cell_number;
                        end
                        reading_sum[m] = reading_sum[m] + reading[m];
                    end
                    cells_counted = cells_counted + 1'b1;
                end

                // The final cell closes the cluster with one report per metric.
                if (s_tlast) begin
                    for (int m = 0; m < NUM_METRICS; m++) begin
                        quotient               = reading_sum[m] / cells_counted;
                        new_report.tag         = s_tdata[S_TAG_LO +: TAG_W];
                        new_report.metric      = metric_t'(m);
                        new_report.max_value   = peak_value[m];
                        new_report.max_cell    = peak_cell[m];
                        new_report.min_value   = floor_value[m];
                        new_report.min_cell    = floor_cell[m];
                        new_report.mean_value  = quotient[FIELD_W-1:0];
                        new_report.last_metric = (metric_t'(m) == METRIC_LAST);
                        expected_reports.push_back(new_report);
                    end
                    clear_stats();
                end
            end
        end
        results_pending = expected_reports.size();
    end

endmodule

/* test/cell_min_max_mean_tracker_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cell min/max/mean tracker testbench
// Drives clusters of cell readings in random bursts: a directed set of
// extremes, ties and tag cases, then random clusters and one cluster past
// the cell capacity. The receiver stalls on its own pattern, with one long
// hold-off. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module cell_min_max_mean_tracker_unit_test;
    import cmmt_pkg::*;

    localparam int MAX_CELLS    = 512;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_CELLS = 60;
    localparam int LONG_CELLS   = MAX_CELLS + 3;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 8;
    localparam int DRAIN_CYCLES = 120;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    int                     mismatch_count;
    int                     results_pending;
    int                     burst_left;
    int                     cycle_count;

    cell_min_max_mean_tracker_unit #(
        .MAX_CELLS   (MAX_CELLS),
        .SAMPLE_BITS (FIELD_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    cell_stats_checker #(
        .MAX_CELLS (MAX_CELLS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Receiver: alternates free-running and stalling stretches, and once
    // holds off for a long time so that the block backs up into its input.
    initial begin
        int  taken;
        int  hold_left;
        int  mode_left;
        bit  stalling;
        bit  held_long;
        taken     = 0;
        hold_left = 0;
        mode_left = 0;
        stalling  = 1'b0;
        held_long = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                taken++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held_long && taken >= HOLD_AFTER) begin
                held_long = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stalling  = ($urandom_range(0, 1) == 0);
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                m_tready <= stalling ? ($urandom_range(0, 2) == 0) : 1'b1;
            end
        end
    end

    // Offers one cell request and waits until it is taken. Requests go out
    // in bursts; between bursts the valid drops and the data carries noise.
    task automatic send_cell(input logic [TAG_W-1:0] cluster, input logic [POS_W-1:0] pos,
                             input logic [FIELD_W-1:0] volt, input logic [FIELD_W-1:0] temp,
                             input logic [FIELD_W-1:0] charge,
                             input logic [FIELD_W-1:0] health, input logic fin);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom, $urandom});
            s_tlast  <= 1'($urandom_range(0, 1));
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, health, charge, temp, volt, pos, cluster};
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Readings leaning on the extremes and on repeated values for ties.
    function automatic logic [FIELD_W-1:0] pick_reading();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 16'd1;
            3:       return 16'hFFFE;
            4, 5:    return 16'd1000;
            default: return FIELD_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] pick_cluster();
        if ($urandom_range(0, 4) == 0)
            return TAG_W'($urandom_range(0, 63));
        return TAG_W'($urandom_range(1, 32));
    endfunction

    // Stimulus.
    initial begin
        int                 sent;
        int                 len;
        logic [TAG_W-1:0]   cluster;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   pos;
        logic [FIELD_W-1:0] volt;
        logic               long_done;
        burst_left = 0;
        long_done  = 1'b0;
        sent       = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // All-zero single cell: no maximum is ever set.
        send_cell(6'd1, 9'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        // All-ones single cell at the top position: no minimum is ever set.
        send_cell(6'd63, 9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // Equal readings: the first cell keeps both extremes.
        send_cell(6'd0, 9'd5, 16'd500, 16'd500, 16'd500, 16'd500, 1'b0);
        send_cell(6'd0, 9'd6, 16'd500, 16'd500, 16'd500, 16'd500, 1'b0);
        send_cell(6'd0, 9'd7, 16'd500, 16'd500, 16'd500, 16'd500, 1'b1);
        // Extremes at different positions for each metric.
        send_cell(6'd32, 9'd0, 16'd3000, 16'd9000, 16'h0000, 16'd700, 1'b0);
        send_cell(6'd32, 9'd1, 16'd3100, 16'd8000, 16'hFFFF, 16'd10, 1'b0);
        send_cell(6'd32, 9'd2, 16'd3200, 16'd7000, 16'd400, 16'd999, 1'b0);
        send_cell(6'd32, 9'd3, 16'd3300, 16'd6000, 16'hFFFF, 16'd10, 1'b0);
        send_cell(6'd32, 9'd4, 16'd3400, 16'd5000, 16'h0000, 16'd998, 1'b1);
        // Cells of other clusters accumulate; the final cell gives the tag.
        send_cell(6'd3, 9'd10, 16'd100, 16'd200, 16'd300, 16'd400, 1'b0);
        send_cell(6'd4, 9'd11, 16'd150, 16'd250, 16'd350, 16'd450, 1'b0);
        send_cell(6'd5, 9'd12, 16'd120, 16'd220, 16'd320, 16'd420, 1'b1);
        // Alternating bit patterns on every field.
        send_cell(6'h2A, 9'h155, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        send_cell(6'h15, 9'h0AA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);

        // Random clusters, with one cluster past the cell capacity midway.
        while (sent < RANDOM_CELLS) begin
            if (!long_done && sent >= RANDOM_CELLS / 2) begin
                // The sums reach their widest here; the last three cells
                // must be left out, and their zero voltage would show it.
                long_done = 1'b1;
                cluster = pick_cluster();
                for (int i = 0; i < LONG_CELLS; i++) begin
                    volt = (i < MAX_CELLS) ? 16'hFFFF : 16'h0000;
                    send_cell(cluster, POS_W'(i), volt, pick_reading(), pick_reading(),
                              (i < MAX_CELLS) ? 16'hFFFF : 16'h0000, i == LONG_CELLS - 1);
                end
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 8);
            cluster   = pick_cluster();
            start_pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 511)) : '0;
            for (int i = 0; i < len; i++) begin
                pos = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 511))
                                                  : start_pos + POS_W'(i);
                // Now and then a cell carries another cluster number.
                send_cell(($urandom_range(0, 9) == 0) ? pick_cluster() : cluster, pos,
                          pick_reading(), pick_reading(), pick_reading(), pick_reading(),
                          i == len - 1);
                sent++;
            end
        end

        // Drain and give the verdict.
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cmmt_pkg.sv
rtl/cmmt_div.sv
rtl/cell_min_max_mean_tracker_unit.sv
rtl/cmmt_checker.sv
test/cell_stats_checker.sv
test/cell_min_max_mean_tracker_unit_test.sv
